### src/qpht_pkg.sv
// ----------------------------------------------------------------------------
// qpht_pkg: shared types and constants
// Status codes, state encoding and beat payload types of the hash table.
// ----------------------------------------------------------------------------
`default_nettype none
package qpht_pkg;

  localparam int DefaultDepth = 64;
  localparam logic [6:0] SizeReset = 7'd11;

  typedef enum logic [1:0] {
    FUNC_INSERT = 2'd0,
    FUNC_SEARCH = 2'd1,
    FUNC_ADOPT  = 2'd2,
    FUNC_NONE   = 2'd3
  } func_t;

  typedef enum logic [2:0] {
    ST_INSERTED  = 3'd0,
    ST_DUPLICATE = 3'd1,
    ST_LOAD_LIM  = 3'd2,
    ST_FOUND     = 3'd3,
    ST_NOT_FOUND = 3'd4,
    ST_ADOPTED   = 3'd5,
    ST_ALREADY   = 3'd6,
    ST_NO_SLOT   = 3'd7
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CLEAR,
    S_SCAN,
    S_SCAN_CHK,
    S_HASH,
    S_PROBE,
    S_PROBE_CHK,
    S_WRITE,
    S_READ,
    S_READ_WAIT,
    S_OUT
  } state_t;

  typedef struct packed {
    logic [1:0]  func;
    logic [30:0] key;
    logic [15:0] weight;
    logic [15:0] height;
    logic [4:0]  date_day;
    logic [3:0]  date_month;
    logic [11:0] date_year;
  } req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [5:0]  slot;
    logic [15:0] rec_weight;
    logic [15:0] rec_height;
    logic [4:0]  entry_day;
    logic [3:0]  entry_month;
    logic [11:0] entry_year;
    logic [4:0]  leave_day;
    logic [3:0]  leave_month;
    logic [11:0] leave_year;
  } rsp_t;

  typedef struct packed {
    logic        used;
    logic [30:0] key;
    logic [31:0] measures;
    logic [20:0] entry_date;
    logic [20:0] leave_date;
  } entry_t;

endpackage
`default_nettype wire

### src/qpht_if.sv
// ----------------------------------------------------------------------------
// qpht_if: valid/ready channel
// Carries one beat of a request or response payload.
// ----------------------------------------------------------------------------
`default_nettype none
interface qpht_req_if;
  import qpht_pkg::*;
  logic valid;
  logic ready;
  req_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface qpht_rsp_if;
  import qpht_pkg::*;
  logic valid;
  logic ready;
  rsp_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

### src/quadratic_probe_hash_table.sv
// ----------------------------------------------------------------------------
// quadratic_probe_hash_table: open-addressing table with quadratic probing
// Insert, search and adopt over a single-port synchronous slot memory.
// ----------------------------------------------------------------------------
// One request beat at a time. After reset a clearing pass writes every one of
// the TABLE_DEPTH slots, one a cycle, before the first request is taken. A
// search or adopt scans slots 0 .. size-1 through the registered memory read,
// ending early on a hit; an adopt of a record not yet adopted then writes its
// leave date. An insert scans slots 0 .. size-1 for a duplicate, reduces the
// key modulo the size, then probes up to size slots and writes the first
// free one. The response beat then waits in an output register until
// taken.
`default_nettype none
module quadratic_probe_hash_table #(
  parameter int TABLE_DEPTH = qpht_pkg::DefaultDepth
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       cfg_we,
  input  wire logic [6:0] cfg_wdata,
  qpht_req_if.sink        req,
  qpht_rsp_if.source      rsp
);
  import qpht_pkg::*;

  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW = AW + 1;
  localparam int KW = 31 + 1;

  entry_t mem [TABLE_DEPTH];
  entry_t rd;
  logic   we;
  logic [AW-1:0] addr;
  entry_t wd;

  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wd;
    rd <= mem[addr];
  end

  state_t state, state_next;
  logic [6:0] table_size;
  logic [6:0] entry_count;
  req_t r;
  rsp_t out_q;
  rsp_t out_next;
  logic out_valid;
  logic [CW-1:0] size, idx, i;
  logic [KW-1:0] rem;
  logic [2:0] red_step;
  logic [CW:0] pos;
  logic [AW-1:0] hit;
  logic [2:0] st;

  always_comb begin
    size = CW'(table_size);
    if (table_size == 7'd0) size = CW'(1);
    if (32'(table_size) > 32'(TABLE_DEPTH)) size = CW'(TABLE_DEPTH);
  end

  logic load_full;
  assign load_full = {entry_count, 1'b0} > 8'(size);

  logic [CW+KW-1:0] sub_v;
  assign sub_v = (CW+KW)'(size) << (3'd6 - red_step) * 5;

  logic last_idx;
  assign last_idx = (idx + 1'b1) >= size;

  // next position = (pos + 2i + 1) mod size, pos<size, 2i+1 < 2*size
  logic [CW+1:0] psum, pm1, pm2;
  always_comb begin
    psum = (CW+2)'(pos) + (CW+2)'({i, 1'b1});
    pm1 = (psum >= (CW+2)'(size)) ? psum - (CW+2)'(size) : psum;
    pm2 = (pm1 >= (CW+2)'(size)) ? pm1 - (CW+2)'(size) : pm1;
  end

  logic rd_hit;
  assign rd_hit = rd.used && (rd.key == r.key);

  logic [AW-1:0] pos_a;
  assign pos_a = pos[AW-1:0];

  logic [KW+4:0] rem_w;
  always_comb begin
    logic [KW+4:0] x;
    x = (KW+5)'(rem);
    for (int k = 4; k >= 0; k--) begin
      if (x >= ((KW+5)'(sub_v) << k)) x = x - ((KW+5)'(sub_v) << k);
    end
    rem_w = x;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (req.valid && !out_valid) begin
          unique case (func_t'(req.data.func))
            FUNC_NONE: state_next = S_IDLE;
            FUNC_INSERT: state_next = load_full ? S_OUT : S_SCAN;
            default: state_next = S_SCAN;
          endcase
        end
      end
      S_CLEAR: if (32'(idx) == TABLE_DEPTH - 1) state_next = S_IDLE;
      S_SCAN: state_next = S_SCAN_CHK;
      S_SCAN_CHK: begin
        if (rd_hit) state_next = (r.func == FUNC_ADOPT && rd.leave_date[4:0] == 5'd0)
                                 ? S_WRITE : S_READ;
        else if (last_idx)
          state_next = (r.func == FUNC_INSERT) ? S_HASH : S_OUT;
        else state_next = S_SCAN;
      end
      S_HASH: if (red_step == 3'd6) state_next = S_PROBE;
      S_PROBE: state_next = S_PROBE_CHK;
      S_PROBE_CHK: begin
        if (!rd.used) state_next = S_WRITE;
        else if (last_idx) state_next = S_OUT;
        else state_next = S_PROBE;
      end
      S_WRITE: state_next = S_READ;
      S_READ: state_next = S_READ_WAIT;
      S_READ_WAIT: state_next = S_OUT;
      S_OUT: state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    we = 1'b0;
    addr = idx[AW-1:0];
    wd = rd;
    unique case (state)
      S_CLEAR: begin
        we = 1'b1;
        wd = '0;
      end
      S_PROBE: addr = pos_a;
      S_WRITE: begin
        we = 1'b1;
        addr = hit;
        if (r.func == FUNC_INSERT) begin
          wd.used = 1'b1;
          wd.key = r.key;
          wd.measures = {r.height, r.weight};
          wd.entry_date = {r.date_year, r.date_month, r.date_day};
          wd.leave_date = '0;
        end else begin
          wd.leave_date = {r.date_year, r.date_month, r.date_day};
        end
      end
      S_READ, S_READ_WAIT: addr = hit;
      default: addr = idx[AW-1:0];
    endcase
  end

  assign req.ready = (state == S_IDLE) && !out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      idx <= '0;
      table_size <= SizeReset;
      entry_count <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) table_size <= cfg_wdata;
      if (rsp.valid && rsp.ready) out_valid <= 1'b0;
      unique case (state)
        S_CLEAR: idx <= idx + 1'b1;
        S_IDLE: begin
          idx <= '0;
          if (req.valid && !out_valid) begin
            r <= req.data;
            if (req.data.func == FUNC_INSERT && load_full) st <= ST_LOAD_LIM;
          end
        end
        S_SCAN_CHK: begin
          idx <= idx + 1'b1;
          if (rd_hit) begin
            hit <= idx[AW-1:0];
            priority case (func_t'(r.func))
              FUNC_INSERT: st <= ST_DUPLICATE;
              FUNC_SEARCH: st <= ST_FOUND;
              default: st <= (rd.leave_date[4:0] != 5'd0) ? ST_ALREADY : ST_ADOPTED;
            endcase
          end else if (last_idx) begin
            st <= ST_NOT_FOUND;
            rem <= KW'(r.key);
            red_step <= '0;
          end
        end
        S_HASH: begin
          rem <= KW'(rem_w);
          red_step <= red_step + 1'b1;
          if (red_step == 3'd6) begin
            pos <= (CW+1)'(rem_w);
            i <= '0;
            idx <= '0;
          end
        end
        S_PROBE_CHK: begin
          if (!rd.used) begin
            hit <= pos_a;
            st <= ST_INSERTED;
            if (entry_count != 7'd127) entry_count <= entry_count + 1'b1;
          end else begin
            st <= ST_NO_SLOT;
            i <= i + 1'b1;
            idx <= idx + 1'b1;
            pos <= (CW+1)'(pm2);
          end
        end
        S_OUT: out_valid <= 1'b1;
        default: ;
      endcase
    end
  end

  logic show;
  assign show = (st != ST_LOAD_LIM) && (st != ST_NOT_FOUND) && (st != ST_NO_SLOT);

  always_comb begin
    out_next = '0;
    out_next.status = st;
    if (show) begin
      out_next.slot = 6'(hit);
      out_next.rec_weight = rd.measures[15:0];
      out_next.rec_height = rd.measures[31:16];
      out_next.entry_day = rd.entry_date[4:0];
      out_next.entry_month = rd.entry_date[8:5];
      out_next.entry_year = rd.entry_date[20:9];
      out_next.leave_day = rd.leave_date[4:0];
      out_next.leave_month = rd.leave_date[8:5];
      out_next.leave_year = rd.leave_date[20:9];
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_OUT) out_q <= out_next;
  end

  assign rsp.valid = out_valid;
  assign rsp.data = out_q;

endmodule
`default_nettype wire
